/* rtl/core/ccc_pkg.sv */
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, constants and the month-length function of the calendar
// clock counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

   localparam logic [15:0] TICKS_PER_TENTH_RST = 16'd100;

   localparam logic [3:0]  TENTH_LAST  = 4'd9;
   localparam logic [5:0]  SECOND_LAST = 6'd59;
   localparam logic [5:0]  MINUTE_LAST = 6'd59;
   localparam logic [4:0]  HOUR_LAST   = 5'd23;
   localparam logic [3:0]  MONTH_LAST  = 4'd12;
   localparam logic [13:0] YEAR_MAX    = 14'd9999;

   localparam logic [4:0]  DAY_FIRST   = 5'd1;
   localparam logic [3:0]  MONTH_FIRST = 4'd1;

   localparam logic [4:0]  DAY_RST     = 5'd31;
   localparam logic [3:0]  MONTH_RST   = 4'd5;
   localparam logic [13:0] YEAR_RST    = 14'd2021;

   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_APR   = 4'd4;
   localparam logic [3:0]  MONTH_JUN   = 4'd6;
   localparam logic [3:0]  MONTH_SEP   = 4'd9;
   localparam logic [3:0]  MONTH_NOV   = 4'd11;

   typedef struct packed {
      logic [15:0] tick_phase;
      logic [3:0]  tenths;
      logic [5:0]  seconds;
      logic [5:0]  minutes;
      logic [4:0]  hours;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } ccc_time_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } ccc_buf_status_type;

   // no leap years: February is always 28 days
   function automatic logic [4:0] ccc_days_in_month(input logic [3:0] month);
      logic [4:0] days;
      case (month) inside
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
         MONTH_FEB:                                  days = 5'd28;
         default:                                    days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

/* rtl/core/ccc_time_next.sv */
// ----------------------------------------------------------------------------
// ccc_time_next
// Next-time logic: prescaler plus the carry chain from tenths up to year.
// ----------------------------------------------------------------------------
module ccc_time_next
   import ccc_pkg::*;
(
   input  ccc_time_type cur_time,
   input  logic [15:0]  ticks_per_tenth,
   input  logic         tick,
   output ccc_time_type next_time
);

   logic [16:0] phase_inc;
   logic        tenth_adv;
   logic        second_adv;
   logic        minute_adv;
   logic        hour_adv;
   logic        day_adv;
   logic        month_adv;
   logic        year_adv;

   // a limit of zero wraps on every tick, same as one
   assign phase_inc  = {1'b0, cur_time.tick_phase} + 17'd1;
   assign tenth_adv  = tick && (phase_inc >= {1'b0, ticks_per_tenth});
   assign second_adv = tenth_adv  && (cur_time.tenths  >= TENTH_LAST);
   assign minute_adv = second_adv && (cur_time.seconds >= SECOND_LAST);
   assign hour_adv   = minute_adv && (cur_time.minutes >= MINUTE_LAST);
   assign day_adv    = hour_adv   && (cur_time.hours   >= HOUR_LAST);
   assign month_adv  = day_adv &&
                       (cur_time.day >= ccc_days_in_month(cur_time.month));
   assign year_adv   = month_adv  && (cur_time.month   >= MONTH_LAST);

   always_comb begin
      next_time = cur_time;
      if (tick) begin
         next_time.tick_phase = tenth_adv ? 16'd0 : phase_inc[15:0];
      end
      if (tenth_adv) begin
         next_time.tenths = second_adv ? 4'd0 : cur_time.tenths + 4'd1;
      end
      if (second_adv) begin
         next_time.seconds = minute_adv ? 6'd0 : cur_time.seconds + 6'd1;
      end
      if (minute_adv) begin
         next_time.minutes = hour_adv ? 6'd0 : cur_time.minutes + 6'd1;
      end
      if (hour_adv) begin
         next_time.hours = day_adv ? 5'd0 : cur_time.hours + 5'd1;
      end
      if (day_adv) begin
         next_time.day = month_adv ? DAY_FIRST : cur_time.day + 5'd1;
      end
      if (month_adv) begin
         next_time.month = year_adv ? MONTH_FIRST : cur_time.month + 4'd1;
      end
      // hold the year at its maximum
      if (year_adv) begin
         next_time.year = (cur_time.year < YEAR_MAX) ? cur_time.year + 14'd1
                                                     : YEAR_MAX;
      end
   end

endmodule

/* rtl/core/ccc_out_buf.sv */
// ----------------------------------------------------------------------------
// ccc_out_buf
// Two-entry result buffer; decouples the response side from request intake.
// ----------------------------------------------------------------------------
module ccc_out_buf
   import ccc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ccc_time_type       push_data,
   input  logic               pop,
   output ccc_buf_status_type status,
   output ccc_time_type       head
);

   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   ccc_time_type slot0_ff;
   ccc_time_type slot0_in;
   ccc_time_type slot1_ff;
   ccc_time_type slot1_in;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               slot0_in = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               slot0_in = push_data;
            end else if (push) begin
               slot1_in = push_data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            // full: no push; advance the second entry to the head
            if (pop) begin
               slot0_in = slot1_ff;
               count_in = 2'd1;
            end
         end
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign status.not_empty = (count_ff != 2'd0);
   assign status.full      = (count_ff == 2'd2);
   assign head             = slot0_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_fill_second: assert property (@(posedge clock) disable iff (reset)
      (push && !pop && count_ff == 2'd1) |=> count_ff == 2'd2)
      else $error("second entry not taken");

   a_shift_head: assert property (@(posedge clock) disable iff (reset)
      (pop && count_ff == 2'd2) |=> slot0_ff == $past(slot1_ff))
      else $error("head not refilled from second entry");

endmodule

/* rtl/core/calendar_clock_counter_core.sv */
// ----------------------------------------------------------------------------
// calendar_clock_counter_core
// Real-time clock and calendar: a prescaler over base ticks drives tenths,
// seconds, minutes, hours, day, month and year; every request returns the time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_tick
//  rsp     | out       | rsp_valid/rsp_ready  | tick_phase .. year
//  csr     | in        | csr_valid/csr_ready  | csr_ticks_per_tenth
//
//  One request per cycle while req_ready is high; each result is registered.
//  The whole carry chain is combinational from the time register.
//  A two-entry result buffer keeps req_ready high while one result waits.
//  Synchronous reset sets 00:00:00.0 on 31.05.2021 and a limit of 100.
//  csr_ready is always high.
// ----------------------------------------------------------------------------
module calendar_clock_counter_core
   import ccc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_tick,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_tick_phase,
   output logic [3:0]  rsp_tenths,
   output logic [5:0]  rsp_seconds,
   output logic [5:0]  rsp_minutes,
   output logic [4:0]  rsp_hours,
   output logic [4:0]  rsp_day,
   output logic [3:0]  rsp_month,
   output logic [13:0] rsp_year,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_ticks_per_tenth
);

   ccc_time_type       time_ff;
   ccc_time_type       time_in;
   ccc_time_type       time_next;
   logic [15:0]        limit_ff;
   logic [15:0]        limit_in;
   logic               req_accept;
   ccc_buf_status_type buf_status;
   ccc_time_type       rsp_head;

   assign csr_ready  = 1'b1;
   assign req_ready  = !buf_status.full;
   assign req_accept = req_valid && req_ready;

   ccc_time_next u_time_next (
      .cur_time        (time_ff),
      .ticks_per_tenth (limit_ff),
      .tick            (req_tick),
      .next_time       (time_next)
   );

   assign limit_in = (csr_valid && csr_ready) ? csr_ticks_per_tenth : limit_ff;
   assign time_in  = req_accept ? time_next : time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TICKS_PER_TENTH_RST;
         time_ff  <= '{tick_phase: 16'd0, tenths: 4'd0, seconds: 6'd0,
                       minutes: 6'd0, hours: 5'd0, day: DAY_RST,
                       month: MONTH_RST, year: YEAR_RST};
      end else begin
         limit_ff <= limit_in;
         time_ff  <= time_in;
      end
   end

   ccc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (time_next),
      .pop       (rsp_valid && rsp_ready),
      .status    (buf_status),
      .head      (rsp_head)
   );

   assign rsp_valid      = buf_status.not_empty;
   assign rsp_tick_phase = rsp_head.tick_phase;
   assign rsp_tenths     = rsp_head.tenths;
   assign rsp_seconds    = rsp_head.seconds;
   assign rsp_minutes    = rsp_head.minutes;
   assign rsp_hours      = rsp_head.hours;
   assign rsp_day        = rsp_head.day;
   assign rsp_month      = rsp_head.month;
   assign rsp_year       = rsp_head.year;

   a_read_holds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_tick) |=> $stable(time_ff))
      else $error("read request changed the time");

   a_day_nonzero: assert property (@(posedge clock) disable iff (reset)
      time_ff.day != 5'd0 && time_ff.month != 4'd0)
      else $error("day or month reached zero");

   a_result_is_time: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !buf_status.not_empty) |=> rsp_head == time_ff)
      else $error("result does not match updated time");

endmodule
